FILE: design/bit_offset_block_copy_defines.svh
// ----------------------------------------------------------------------------
// bit_offset_block_copy_defines.svh
// Assertion macros shared by the bit offset block copy design.
// ----------------------------------------------------------------------------
`ifndef BIT_OFFSET_BLOCK_COPY_DEFINES_SVH
`define BIT_OFFSET_BLOCK_COPY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BOBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bit_offset_block_copy: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BOBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bit_offset_block_copy: next-cycle check failed");

`endif

FILE: design/bobc_pkg.sv
// ----------------------------------------------------------------------------
// bobc_pkg
// Beat types, action codes and controller states of the bit offset block copy.
// ----------------------------------------------------------------------------
package bobc_pkg;

  // Action codes
  localparam logic [1:0] ACT_LOAD_SRC = 2'd0;
  localparam logic [1:0] ACT_LOAD_DST = 2'd1;
  localparam logic [1:0] ACT_READ_DST = 2'd2;
  localparam logic [1:0] ACT_COPY     = 2'd3;

  // Status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] byte_address;
    logic [7:0]  byte_data;
    logic [14:0] source_bit;
    logic [15:0] bit_count;
    logic [14:0] dest_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_LOAD,
    ST_BITS
  } state_t;

endpackage

FILE: design/bobc_ram.sv
// ----------------------------------------------------------------------------
// bobc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bobc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/bit_offset_block_copy.sv
// ----------------------------------------------------------------------------
// bit_offset_block_copy
// Source and destination byte stores with a bit-serial, bit-aligned copy.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per command (load source byte, load destination byte,
//           read destination byte, copy bits). Accepted on in_valid & in_ready.
//   out_* : exactly one result beat per command: read_byte for a read,
//           status 1 for a rejected copy (zero length or past a store end).
//   Loads, out-of-range reads and rejected copies: result is registered at
//   the accepting edge, ready again the next cycle unless the queue is full.
//   Reads: ST_READ follows the accepting cycle and pushes the registered RAM read.
//   Copies: one bit per cycle in ST_BITS, with a fetch and a load step
//   (ST_FETCH, ST_LOAD) at the start and at every source or destination
//   byte boundary.
//   Bits are LSB first: bit k of byte b is bit 8b+k.
//   A two-entry output queue lets the next command in while a result waits;
//   in_ready drops only when both entries are full or the engine is busy.
//   Reset (rst_n low, synchronous) empties the queue and idles the engine;
//   store contents are undefined until written.
// ----------------------------------------------------------------------------
`include "bit_offset_block_copy_defines.svh"

module bit_offset_block_copy #(
  parameter int SRC_BYTES = 4096,
  parameter int DST_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bobc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bobc_pkg::out_item_t out_data
);

  localparam int SAW = (SRC_BYTES > 1) ? $clog2(SRC_BYTES) : 1;
  localparam int DAW = (DST_BYTES > 1) ? $clog2(DST_BYTES) : 1;
  localparam int SBW = SAW + 3;
  localparam int DBW = DAW + 3;
  localparam longint unsigned SRC_BITS = 64'(SRC_BYTES) * 64'd8;
  localparam longint unsigned DST_BITS = 64'(DST_BYTES) * 64'd8;

  bobc_pkg::state_t state_r, state_nxt;

  logic [SBW-1:0] spos_r, spos_nxt;
  logic [DBW-1:0] dpos_r, dpos_nxt;
  logic [15:0]    remain_r, remain_nxt;
  logic [7:0]     src_byte_r, src_byte_nxt;
  logic [7:0]     dst_byte_r, dst_byte_nxt;

  logic                out_valid_r;
  bobc_pkg::out_item_t out_data_r;
  logic                skid_valid_r;
  bobc_pkg::out_item_t skid_data_r;

  logic                res_push;
  bobc_pkg::out_item_t res_data;

  logic           src_we;
  logic [SAW-1:0] src_waddr;
  logic [SAW-1:0] src_raddr;
  logic [7:0]     src_rdata;
  logic           dst_we;
  logic [DAW-1:0] dst_waddr;
  logic [7:0]     dst_wdata;
  logic [DAW-1:0] dst_raddr;
  logic [7:0]     dst_rdata;

  logic        in_fire;
  logic        src_in_range;
  logic        dst_in_range;
  logic [16:0] src_end;
  logic [16:0] dst_end;
  logic        copy_reject;
  logic        bit_last;
  logic        bit_leave;
  logic [7:0]  dst_byte_mod;

  // Stores
  bobc_ram #(.WIDTH(8), .DEPTH(SRC_BYTES)) u_src_ram (
    .clk     (clk),
    .wr_en   (src_we),
    .wr_addr (src_waddr),
    .wr_data (in_data.byte_data),
    .rd_addr (src_raddr),
    .rd_data (src_rdata)
  );

  bobc_ram #(.WIDTH(8), .DEPTH(DST_BYTES)) u_dst_ram (
    .clk     (clk),
    .wr_en   (dst_we),
    .wr_addr (dst_waddr),
    .wr_data (dst_wdata),
    .rd_addr (dst_raddr),
    .rd_data (dst_rdata)
  );

  // Command decode
  assign in_ready     = (state_r == bobc_pkg::ST_IDLE) && !skid_valid_r;
  assign in_fire      = in_valid && in_ready;
  assign src_in_range = 64'(in_data.byte_address) < 64'(SRC_BYTES);
  assign dst_in_range = 64'(in_data.byte_address) < 64'(DST_BYTES);
  assign src_end      = 17'(in_data.source_bit) + 17'(in_data.bit_count);
  assign dst_end      = 17'(in_data.dest_bit) + 17'(in_data.bit_count);
  assign copy_reject  = (in_data.bit_count == 16'd0) ||
                        (64'(src_end) > SRC_BITS) ||
                        (64'(dst_end) > DST_BITS);

  // Bit step: move one source bit into the working destination byte
  always_comb begin
    dst_byte_mod = dst_byte_r;
    dst_byte_mod[dpos_r[2:0]] = src_byte_r[spos_r[2:0]];
  end

  assign bit_last  = (remain_r == 16'd1);
  assign bit_leave = bit_last || (spos_r[2:0] == 3'd7) || (dpos_r[2:0] == 3'd7);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bobc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((in_data.action == bobc_pkg::ACT_READ_DST) && dst_in_range) begin
            state_nxt = bobc_pkg::ST_READ;
          end else if ((in_data.action == bobc_pkg::ACT_COPY) && !copy_reject) begin
            state_nxt = bobc_pkg::ST_FETCH;
          end
        end
      end
      bobc_pkg::ST_READ:  state_nxt = bobc_pkg::ST_IDLE;
      bobc_pkg::ST_FETCH: state_nxt = bobc_pkg::ST_LOAD;
      bobc_pkg::ST_LOAD:  state_nxt = bobc_pkg::ST_BITS;
      bobc_pkg::ST_BITS: begin
        if (bit_leave) begin
          state_nxt = bit_last ? bobc_pkg::ST_IDLE : bobc_pkg::ST_FETCH;
        end
      end
      default: state_nxt = bobc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller: RAM ports, datapath updates, result pushes
  always_comb begin
    spos_nxt     = spos_r;
    dpos_nxt     = dpos_r;
    remain_nxt   = remain_r;
    src_byte_nxt = src_byte_r;
    dst_byte_nxt = dst_byte_r;
    src_we       = 1'b0;
    src_waddr    = SAW'(in_data.byte_address);
    src_raddr    = spos_r[SBW-1:3];
    dst_we       = 1'b0;
    dst_waddr    = DAW'(in_data.byte_address);
    dst_wdata    = in_data.byte_data;
    dst_raddr    = DAW'(in_data.byte_address);
    res_push     = 1'b0;
    res_data     = '{read_byte: 8'd0, status: bobc_pkg::STATUS_OK};
    case (state_r)
      bobc_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.action)
            bobc_pkg::ACT_LOAD_SRC: begin
              src_we   = src_in_range;
              res_push = 1'b1;
            end
            bobc_pkg::ACT_LOAD_DST: begin
              dst_we   = dst_in_range;
              res_push = 1'b1;
            end
            bobc_pkg::ACT_READ_DST: begin
              // in range: result comes from the RAM next cycle
              res_push = !dst_in_range;
            end
            bobc_pkg::ACT_COPY: begin
              spos_nxt   = SBW'(in_data.source_bit);
              dpos_nxt   = DBW'(in_data.dest_bit);
              remain_nxt = in_data.bit_count;
              if (copy_reject) begin
                res_push        = 1'b1;
                res_data.status = bobc_pkg::STATUS_REJECT;
              end
            end
            default: ;
          endcase
        end
      end
      bobc_pkg::ST_READ: begin
        res_push           = 1'b1;
        res_data.read_byte = dst_rdata;
      end
      bobc_pkg::ST_FETCH: begin
        src_raddr = spos_r[SBW-1:3];
        dst_raddr = dpos_r[DBW-1:3];
      end
      bobc_pkg::ST_LOAD: begin
        src_byte_nxt = src_rdata;
        dst_byte_nxt = dst_rdata;
      end
      bobc_pkg::ST_BITS: begin
        spos_nxt     = spos_r + SBW'(1);
        dpos_nxt     = dpos_r + DBW'(1);
        remain_nxt   = remain_r - 16'd1;
        dst_byte_nxt = dst_byte_mod;
        // write back the working byte whenever either byte is used up or on the last bit
        if (bit_leave) begin
          dst_we    = 1'b1;
          dst_waddr = dpos_r[DBW-1:3];
          dst_wdata = dst_byte_mod;
          res_push  = bit_last;
        end
      end
      default: ;
    endcase
  end

  // Controller and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bobc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    spos_r     <= spos_nxt;
    dpos_r     <= dpos_nxt;
    remain_r   <= remain_nxt;
    src_byte_r <= src_byte_nxt;
    dst_byte_r <= dst_byte_nxt;
  end

  // Two-entry result queue: output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_push;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= res_push;
    end else if (res_push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= res_data;
      end
    end else if (!out_valid_r || out_ready) begin
      out_data_r <= res_data;
    end else if (res_push) begin
      skid_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `BOBC_ASSERT_NOW(a_no_push_when_full, res_push, !skid_valid_r)
  `BOBC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `BOBC_ASSERT_NOW(a_bits_remaining, state_r == bobc_pkg::ST_BITS, remain_r != 16'd0)
  `BOBC_ASSERT_NEXT(a_copy_starts,
    in_fire && (in_data.action == bobc_pkg::ACT_COPY) && !copy_reject,
    state_r == bobc_pkg::ST_FETCH)

endmodule
